>>> design/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package olid_pkg;

    localparam int OLID_CAPACITY   = 64;
    localparam int OLID_DATA_WIDTH = 32;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 7;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [ST_W-1:0] ST_NONE   = 2'd3;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_FIND   = 2'd2,
        FN_GET    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        C_HOLD,
        C_INSERT,
        C_DELETE,
        C_LOAD,
        C_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     load_find;
    } t_cell_ctrl;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] found;
        logic [VAL_W-1:0] rd;
        logic [LEN_W-1:0] len;
        logic             empty;
    } t_result;

endpackage

>>> design/olid_cell.sv
// ----------------------------------------------------------------------------
// olid_cell
// One list slot: holds an entry, shifts it up or down with its neighbors,
// and carries a scan tag (hit flag and data) that moves toward the head.
// ----------------------------------------------------------------------------
module olid_cell
    import olid_pkg::*;
#(
    parameter int DATA_WIDTH = OLID_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_new,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic                  i_right_hit,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_ge,
    input  logic                  i_at,
    input  logic                  i_live,
    output logic [DATA_WIDTH-1:0] o_val,
    output logic                  o_hit,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_val;
    logic                  r_hit;
    logic [DATA_WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            C_INSERT: begin
                if (i_at) begin
                    r_val <= i_new;
                end else if (i_ge) begin
                    r_val <= i_left;
                end
            end
            C_DELETE: begin
                if (i_ge) begin
                    r_val <= i_right;
                end
            end
            C_LOAD: begin
                // find tags live matches, get tags the addressed slot
                r_hit  <= i_ctrl.load_find ? (i_live && (r_val == i_new)) : i_at;
                r_data <= r_val;
            end
            C_SHIFT: begin
                r_hit  <= i_right_hit;
                r_data <= i_right_data;
            end
            default: begin
            end
        endcase
    end

    assign o_val  = r_val;
    assign o_hit  = r_hit;
    assign o_data = r_data;

endmodule

>>> design/ordered_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core
// Ordered list of signed values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Insert, delete and any rejected operation need no scan: the beat is
// accepted, every cell shifts in parallel, and the result lands in the
// output register at the same edge, so these run back to back as long as
// the output is drained. Find and get load a scan tag into every cell and
// then scan until a hit reaches the head or the whole list has passed it:
// the tags travel one cell per cycle toward the head, where the head cell's
// hit flag picks off the first hit. A new beat is taken once the previous
// one has left for the output register. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core
    import olid_pkg::*;
#(
    parameter int CAPACITY   = OLID_CAPACITY,
    parameter int DATA_WIDTH = OLID_DATA_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [POS_W-1:0]  i_position,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [POS_W-1:0]  o_found_position,
    output logic [VAL_W-1:0]  o_read_value,
    output logic [LEN_W-1:0]  o_list_length,
    output logic              o_list_empty
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SW  = $clog2(CAPACITY);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int DW  = DATA_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_scan_idx;
    logic              r_scan_find;
    logic              r_out_valid;
    t_result           r_out;
    t_result           r_pend;

    t_func             func;
    logic              acc;
    logic              out_free;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic              full;
    logic              ins_bad;
    logic              rng_bad;
    logic [DW-1:0]     new_val;
    logic [VAL_W-1:0]  head_rd;
    logic [CW-1:0]     idx_p1;

    t_cell_ctrl        ctrl;
    logic              go_scan;
    logic              res_fire;
    t_result           res;
    logic [CW-1:0]     n_count;

    logic [DW-1:0]     val  [CAPACITY];
    logic              hit  [CAPACITY];
    logic [DW-1:0]     sdat [CAPACITY];
    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] at;
    logic [CAPACITY-1:0] live;

    assign func     = t_func'(i_func);
    assign acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign pos_ext  = PW'(i_position);
    assign cnt_ext  = PW'(r_count);
    assign full     = (r_count == CW'(CAPACITY));
    assign ins_bad  = (i_position == '0) ||
                      ((PW+1)'(pos_ext) > ((PW+1)'(cnt_ext) + (PW+1)'(1)));
    assign rng_bad  = (i_position == '0) || (pos_ext > cnt_ext);
    assign idx_p1   = CW'(r_scan_idx) + CW'(1);

    // width adaption between the 32-bit ports and the stored word
    if (DW <= VAL_W) begin : g_in_cut
        assign new_val = i_value[DW-1:0];
    end else begin : g_in_ext
        assign new_val = {{(DW-VAL_W){i_value[VAL_W-1]}}, i_value};
    end

    if (DW >= VAL_W) begin : g_out_cut
        assign head_rd = sdat[0][VAL_W-1:0];
    end else begin : g_out_ext
        assign head_rd = {{(VAL_W-DW){sdat[0][DW-1]}}, sdat[0]};
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [PW-1:0] IDX1 = PW'(gi + 1);
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;
        logic          w_rhit;
        logic [DW-1:0] w_rdata;

        assign ge[gi]   = (pos_ext <= IDX1);
        assign at[gi]   = (pos_ext == IDX1);
        assign live[gi] = (cnt_ext >= IDX1);

        if (gi == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = val[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = val[gi];
            assign w_rhit  = 1'b0;
            assign w_rdata = '0;
        end else begin : g_body
            assign w_right = val[gi+1];
            assign w_rhit  = hit[gi+1];
            assign w_rdata = sdat[gi+1];
        end

        olid_cell #(
            .DATA_WIDTH (DW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_new        (new_val),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_right_hit  (w_rhit),
            .i_right_data (w_rdata),
            .i_ge         (ge[gi]),
            .i_at         (at[gi]),
            .i_live       (live[gi]),
            .o_val        (val[gi]),
            .o_hit        (hit[gi]),
            .o_data       (sdat[gi])
        );
    end

    always_comb begin
        ctrl.op        = C_HOLD;
        ctrl.load_find = 1'b0;
        go_scan        = 1'b0;
        res_fire       = 1'b0;
        res.status     = ST_OK;
        res.found      = '0;
        res.rd         = '0;
        n_count        = r_count;
        if (acc) begin
            unique case (func)
                FN_INSERT: begin
                    res_fire = 1'b1;
                    if (full) begin
                        res.status = ST_FULL;
                    end else if (ins_bad) begin
                        res.status = ST_BADPOS;
                    end else begin
                        ctrl.op = C_INSERT;
                        n_count = r_count + CW'(1);
                    end
                end
                FN_DELETE: begin
                    res_fire = 1'b1;
                    if (r_count == '0) begin
                        res.status = ST_NONE;
                    end else if (rng_bad) begin
                        res.status = ST_BADPOS;
                    end else begin
                        ctrl.op = C_DELETE;
                        n_count = r_count - CW'(1);
                    end
                end
                FN_FIND: begin
                    if (r_count == '0) begin
                        res_fire   = 1'b1;
                        res.status = ST_NONE;
                    end else begin
                        ctrl.op        = C_LOAD;
                        ctrl.load_find = 1'b1;
                        go_scan        = 1'b1;
                    end
                end
                FN_GET: begin
                    if (rng_bad) begin
                        res_fire   = 1'b1;
                        res.status = ST_BADPOS;
                    end else begin
                        ctrl.op = C_LOAD;
                        go_scan = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == S_SCAN) begin
            if (hit[0]) begin
                res_fire = 1'b1;
                if (r_scan_find) begin
                    res.found = POS_W'(idx_p1);
                end else begin
                    res.rd = head_rd;
                end
            end else if (idx_p1 >= r_count) begin
                res_fire   = 1'b1;
                res.status = ST_NONE;
            end else begin
                ctrl.op = C_SHIFT;
            end
        end
        res.len   = LEN_W'(n_count);
        res.empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (r_out_valid && !i_out_stall && !res_fire && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (go_scan) begin
                        r_state     <= S_SCAN;
                        r_scan_idx  <= '0;
                        r_scan_find <= (func == FN_FIND);
                    end
                end
                S_SCAN: begin
                    if (!res_fire) begin
                        r_scan_idx <= r_scan_idx + SW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (res_fire) begin
                if (out_free) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end else begin
                    // output still held: park the beat
                    r_pend  <= res;
                    r_state <= S_DONE;
                end
            end
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.found;
    assign o_read_value     = r_out.rd;
    assign o_list_length    = r_out.len;
    assign o_list_empty     = r_out.empty;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_scan_idx) < r_count))
        else $error("scan index ran past list length");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (func == FN_INSERT) && full) |=> (r_count == $past(r_count)))
        else $error("refused insert changed the count");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
            ((o_found_position == '0) && (o_read_value == '0)))
        else $error("failed result carries data");

    a_parked_means_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_out_valid)
        else $error("result parked while output register empty");

endmodule
